// File: design/mvna_pkg.sv
// shared constants and types for the vertex normal accumulator
`timescale 1ns / 1ps
package mvna_pkg;
  localparam int VERTEX_COUNT_DEF = 4096;
  localparam int COORD_BITS_DEF   = 20;
  localparam int SUM_BITS_DEF     = 24;
  localparam int SLOT_W           = 12;
  localparam int NORMAL_W         = 24;
  localparam int UNIT_SHIFT       = 14;
  localparam int MAG_LIMIT_BITS   = 30;

  typedef enum logic [1:0] {
    KIND_STORE = 2'd0,
    KIND_ACCUM = 2'd1,
    KIND_EMIT  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;
endpackage

// File: design/mesh_vertex_normal_accumulator.sv
// top level: vertex store, iterative normal unit and saturating sum update
//
//  channel | ports                                   | handshake
//  in      | in_kind .. in_corner_c                  | start & !busy
//  out     | out_normal_x/y/z, out_corner_number, out_last | out_valid, one cycle
//
// a store request, an unused kind or an accumulate with a corner out of range leaves
// busy low; an emit request keeps busy high until its three results are out. an
// accumulate request keeps busy high through the corner fetch, the magnitude shifts
// and the arithmetic: one shared multiplier for the 6 cross terms and 3 squares, a
// 2-bit-per-cycle square root (31 steps), a 1-bit-per-cycle divider used three
// times (45 steps plus 1 setup each), then a read-modify-write of each corner sum.
// the memories are undefined after reset; reset clears only state_r, out_valid and out_last.
// results cannot be stalled: each is flagged by out_valid for exactly one cycle.
`timescale 1ns / 1ps
module mesh_vertex_normal_accumulator #(
  parameter int VERTEX_COUNT = mvna_pkg::VERTEX_COUNT_DEF,
  parameter int COORD_BITS   = mvna_pkg::COORD_BITS_DEF,
  parameter int SUM_BITS     = mvna_pkg::SUM_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_kind,
  input  logic [mvna_pkg::SLOT_W-1:0]  in_vertex_slot,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  input  logic [mvna_pkg::SLOT_W-1:0]  in_corner_a,
  input  logic [mvna_pkg::SLOT_W-1:0]  in_corner_b,
  input  logic [mvna_pkg::SLOT_W-1:0]  in_corner_c,
  output logic                         out_valid,
  output logic signed [mvna_pkg::NORMAL_W-1:0] out_normal_x,
  output logic signed [mvna_pkg::NORMAL_W-1:0] out_normal_y,
  output logic signed [mvna_pkg::NORMAL_W-1:0] out_normal_z,
  output logic [1:0]                   out_corner_number,
  output logic                         out_last
);
  localparam int AW  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int EW  = COORD_BITS + 1;           // edge width
  localparam int PW  = 2 * EW;                   // product width
  localparam int CW  = PW + 1;                   // cross component width
  localparam int MW  = mvna_pkg::MAG_LIMIT_BITS; // magnitude after shift
  localparam int QW  = 2 * MW + 2;               // sum of squares width
  localparam int RW  = MW + 1;                   // root width
  localparam int SQ_STEPS = QW / 2;
  localparam int NUMW = MW + mvna_pkg::UNIT_SHIFT + 1;
  localparam int NW  = mvna_pkg::NORMAL_W;
  localparam int DCW = $clog2(NUMW + 1);
  localparam int SCW = $clog2(SQ_STEPS + 1);
  localparam logic signed [SUM_BITS:0] SUM_HI = {2'b00, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS:0] SUM_LO = ~SUM_HI;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_RDW, S_EDGE, S_MUL, S_MAG, S_SHIFT, S_SQ, S_ROOT, S_DIVI, S_DIV,
    S_ADDRD, S_ADDRDW, S_ADDWR, S_EMRD, S_EMRDW, S_EMOUT
  } state_t;

  // memories
  logic signed [COORD_BITS-1:0] mem_px [VERTEX_COUNT];
  logic signed [COORD_BITS-1:0] mem_py [VERTEX_COUNT];
  logic signed [COORD_BITS-1:0] mem_pz [VERTEX_COUNT];
  logic signed [SUM_BITS-1:0]   mem_sx [VERTEX_COUNT];
  logic signed [SUM_BITS-1:0]   mem_sy [VERTEX_COUNT];
  logic signed [SUM_BITS-1:0]   mem_sz [VERTEX_COUNT];

  state_t state_r;
  logic [AW-1:0] crn_r [3];
  logic [2:0]  crn_ok_r;
  logic [1:0]  idx_r;
  logic [3:0]  step_r;
  logic signed [COORD_BITS-1:0] rdx_r, rdy_r, rdz_r;
  logic signed [SUM_BITS-1:0]   rsx_r, rsy_r, rsz_r;
  logic signed [COORD_BITS-1:0] pa_r [3];
  logic signed [COORD_BITS-1:0] pb_r [3];
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [PW-1:0] prod_r;
  logic signed [CW-1:0] cr_r [3];
  logic [CW-1:0] mag_r [3];
  logic [QW-1:0] sq_r, rem_r;
  logic [RW-1:0] root_r;
  logic [SCW-1:0] sqc_r;
  logic [NUMW-1:0] num_r;
  logic [RW:0] drem_r;
  logic [DCW-1:0] dcnt_r;
  logic signed [NW-1:0] nrm_r [3];
  logic [AW-1:0] rd_addr;
  logic rd_en;

  // edge multiplier operand selection, one product per step
  logic signed [EW-1:0] ma, mb;
  always_comb begin
    unique case (step_r[2:0])
      3'd0: begin ma = e1_r[1]; mb = e2_r[2]; end
      3'd1: begin ma = e1_r[2]; mb = e2_r[1]; end
      3'd2: begin ma = e1_r[2]; mb = e2_r[0]; end
      3'd3: begin ma = e1_r[0]; mb = e2_r[2]; end
      3'd4: begin ma = e1_r[0]; mb = e2_r[1]; end
      default: begin ma = e1_r[1]; mb = e2_r[0]; end
    endcase
  end

  // square operand for the magnitudes
  logic [MW-1:0] sqop;
  always_comb begin
    unique case (step_r[1:0])
      2'd0: sqop = mag_r[0][MW-1:0];
      2'd1: sqop = mag_r[1][MW-1:0];
      default: sqop = mag_r[2][MW-1:0];
    endcase
  end

  // shared multiplier: cross terms first, then the magnitude squares
  logic signed [MW:0]   mul_a, mul_b;
  logic signed [QW-1:0] mul_p;
  always_comb begin
    if (state_r == S_SQ) begin
      mul_a = $signed({1'b0, sqop});
      mul_b = $signed({1'b0, sqop});
    end else begin
      mul_a = (MW+1)'(ma);
      mul_b = (MW+1)'(mb);
    end
  end
  assign mul_p = mul_a * mul_b;

  // square root trial
  logic [QW-1:0] sq_trial;
  logic [QW+1:0] rem_sh;
  assign rem_sh   = {rem_r, sq_r[QW-1 -: 2]};
  assign sq_trial = {{(QW-RW-2){1'b0}}, root_r, 2'b01};

  // divider trial
  logic [RW:0] d_sh;
  assign d_sh = {drem_r[RW-1:0], num_r[NUMW-1]};

  // saturating add for the sum update
  function automatic logic signed [SUM_BITS-1:0] sat_add(logic signed [SUM_BITS-1:0] s,
                                                         logic signed [NW-1:0] n);
    logic signed [SUM_BITS+NW:0] t;
    t = $signed({{(NW+1){s[SUM_BITS-1]}}, s}) + $signed({{(SUM_BITS+1){n[NW-1]}}, n});
    if (t > $signed({{NW{SUM_HI[SUM_BITS]}}, SUM_HI}))
      return SUM_HI[SUM_BITS-1:0];
    else if (t < $signed({{NW{SUM_LO[SUM_BITS]}}, SUM_LO}))
      return SUM_LO[SUM_BITS-1:0];
    return t[SUM_BITS-1:0];
  endfunction

  // output clamp from sum width to the 24-bit field
  function automatic logic signed [NW-1:0] clamp_out(logic signed [SUM_BITS-1:0] s);
    logic signed [SUM_BITS+NW-1:0] t;
    logic signed [SUM_BITS+NW-1:0] hi;
    t  = {{NW{s[SUM_BITS-1]}}, s};
    hi = (SUM_BITS+NW)'({1'b0, {(NW-1){1'b1}}});
    if (t > hi) return {1'b0, {(NW-1){1'b1}}};
    else if (t < ~hi) return {1'b1, {(NW-1){1'b0}}};
    return t[NW-1:0];
  endfunction

  // read address of the position and sum memories
  always_comb begin
    rd_en   = (state_r == S_RD) || (state_r == S_ADDRD) || (state_r == S_EMRD);
    rd_addr = crn_r[idx_r];
  end

  // memory read ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdx_r <= mem_px[rd_addr];
      rdy_r <= mem_py[rd_addr];
      rdz_r <= mem_pz[rd_addr];
      rsx_r <= mem_sx[rd_addr];
      rsy_r <= mem_sy[rd_addr];
      rsz_r <= mem_sz[rd_addr];
    end
  end

  // memory write ports: vertex store and sum update
  always_ff @(posedge clk) begin
    if (rst_n && state_r == S_IDLE && start && in_kind == mvna_pkg::KIND_STORE &&
        32'(in_vertex_slot) < VERTEX_COUNT) begin
      mem_px[AW'(in_vertex_slot)] <= in_pos_x;
      mem_py[AW'(in_vertex_slot)] <= in_pos_y;
      mem_pz[AW'(in_vertex_slot)] <= in_pos_z;
      mem_sx[AW'(in_vertex_slot)] <= '0;
      mem_sy[AW'(in_vertex_slot)] <= '0;
      mem_sz[AW'(in_vertex_slot)] <= '0;
    end else if (state_r == S_ADDWR) begin
      mem_sx[crn_r[idx_r]] <= sat_add(rsx_r, nrm_r[0]);
      mem_sy[crn_r[idx_r]] <= sat_add(rsy_r, nrm_r[1]);
      mem_sz[crn_r[idx_r]] <= sat_add(rsz_r, nrm_r[2]);
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      out_valid <= (state_r == S_EMOUT);
      out_last  <= (state_r == S_EMOUT) && (idx_r == 2'd2);
      unique case (state_r)
        S_IDLE: begin
          crn_r[0] <= AW'(in_corner_a);
          crn_r[1] <= AW'(in_corner_b);
          crn_r[2] <= AW'(in_corner_c);
          crn_ok_r <= {32'(in_corner_c) < VERTEX_COUNT, 32'(in_corner_b) < VERTEX_COUNT,
                       32'(in_corner_a) < VERTEX_COUNT};
          idx_r  <= 2'd0;
          step_r <= 4'd0;
          if (start) begin
            if (in_kind == mvna_pkg::KIND_ACCUM) begin
              if (32'(in_corner_a) < VERTEX_COUNT && 32'(in_corner_b) < VERTEX_COUNT &&
                  32'(in_corner_c) < VERTEX_COUNT)
                state_r <= S_RD;
            end else if (in_kind == mvna_pkg::KIND_EMIT) begin
              state_r <= S_EMRD;
            end
          end
        end
        // fetch the three corner positions
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          if (idx_r == 2'd0) begin
            pa_r[0] <= rdx_r; pa_r[1] <= rdy_r; pa_r[2] <= rdz_r;
          end else if (idx_r == 2'd1) begin
            pb_r[0] <= rdx_r; pb_r[1] <= rdy_r; pb_r[2] <= rdz_r;
          end else begin
            for (int k = 0; k < 3; k++)
              e1_r[k] <= EW'(pb_r[k]) - EW'(pa_r[k]);
            e2_r[0] <= EW'(rdx_r) - EW'(pa_r[0]);
            e2_r[1] <= EW'(rdy_r) - EW'(pa_r[1]);
            e2_r[2] <= EW'(rdz_r) - EW'(pa_r[2]);
          end
          if (idx_r == 2'd2) begin
            state_r <= S_EDGE;
            step_r  <= 4'd0;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_RD;
          end
        end
        S_EDGE: begin
          prod_r  <= PW'(mul_p);
          step_r  <= 4'd1;
          state_r <= S_MUL;
        end
        // cross product: even steps hold the first term, odd steps subtract
        S_MUL: begin
          if (step_r[0])
            cr_r[step_r[2:1]] <= CW'(prod_r) - CW'(mul_p);
          else
            prod_r <= PW'(mul_p);
          if (step_r == 4'd6) begin
            state_r <= S_MAG;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_MAG: begin
          for (int k = 0; k < 3; k++)
            mag_r[k] <= cr_r[k][CW-1] ? CW'(-cr_r[k]) : CW'(cr_r[k]);
          state_r <= S_SHIFT;
        end
        // shift right until the largest magnitude is below the limit
        S_SHIFT: begin
          if ((mag_r[0] | mag_r[1] | mag_r[2]) == '0) begin
            state_r <= S_IDLE;
          end else if (((mag_r[0] | mag_r[1] | mag_r[2]) >> MW) != '0) begin
            for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
          end else begin
            sq_r    <= '0;
            step_r  <= 4'd0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sq_r <= sq_r + $unsigned(mul_p);
          if (step_r == 4'd2) begin
            rem_r   <= '0;
            root_r  <= '0;
            sqc_r   <= '0;
            state_r <= S_ROOT;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        // square root, two bits of the radicand per cycle
        S_ROOT: begin
          sq_r <= sq_r << 2;
          if (rem_sh >= {2'b00, sq_trial}) begin
            rem_r  <= QW'(rem_sh - {2'b00, sq_trial});
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh[QW-1:0];
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          sqc_r <= sqc_r + SCW'(1);
          if (sqc_r == SCW'(SQ_STEPS - 1)) begin
            idx_r   <= 2'd0;
            state_r <= S_DIVI;
          end
        end
        S_DIVI: begin
          if (root_r == '0) begin
            state_r <= S_IDLE;
          end else begin
            num_r  <= NUMW'({mag_r[idx_r][MW-1:0], {mvna_pkg::UNIT_SHIFT{1'b0}}}) +
                      NUMW'(root_r >> 1);
            drem_r <= '0;
            dcnt_r <= '0;
            state_r <= S_DIV;
          end
        end
        // restoring division, one quotient bit per cycle
        S_DIV: begin
          if (d_sh >= {1'b0, root_r}) begin
            drem_r <= d_sh - {1'b0, root_r};
            num_r  <= {num_r[NUMW-2:0], 1'b1};
          end else begin
            drem_r <= d_sh;
            num_r  <= {num_r[NUMW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + DCW'(1);
          if (dcnt_r == DCW'(NUMW - 1)) begin
            if (idx_r == 2'd2) begin
              state_r <= S_ADDRD;
              idx_r   <= 2'd0;
            end else begin
              state_r <= S_DIVI;
              idx_r   <= idx_r + 2'd1;
            end
          end
        end
        S_ADDRD: state_r <= S_ADDRDW;
        S_ADDRDW: state_r <= S_ADDWR;
        S_ADDWR: begin
          if (idx_r == 2'd2) begin
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_ADDRD;
          end
        end
        // emit the three corner sums
        S_EMRD: state_r <= S_EMRDW;
        S_EMRDW: state_r <= S_EMOUT;
        S_EMOUT: begin
          out_corner_number <= idx_r;
          out_normal_x <= crn_ok_r[idx_r] ? clamp_out(rsx_r) : '0;
          out_normal_y <= crn_ok_r[idx_r] ? clamp_out(rsy_r) : '0;
          out_normal_z <= crn_ok_r[idx_r] ? clamp_out(rsz_r) : '0;
          if (idx_r == 2'd2) begin
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= S_EMRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // quotient capture with the sign of the cross component restored
  always_ff @(posedge clk) begin
    if (state_r == S_DIV && dcnt_r == DCW'(NUMW - 1)) begin
      nrm_r[idx_r] <= cr_r[idx_r][CW-1] ? -NW'({num_r[NUMW-2:0], d_sh >= {1'b0, root_r}})
                                        :  NW'({num_r[NUMW-2:0], d_sh >= {1'b0, root_r}});
    end
  end

  assign busy = (state_r != S_IDLE);

  // results only come out of the emit sequence
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_EMOUT)
    else $error("result outside emit");
  // the last flag marks the third corner
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_corner_number == 2'd2)))
    else $error("last flag mismatch");
  // a request is only taken while idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> state_r == S_IDLE)
    else $error("request taken while busy");
endmodule
